// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, ignored while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/qdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// qdtq_pkg
// shared constants, types and saturation helpers of the quaternion delta
// table quantizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qdtq_pkg;

    localparam int COMP_BITS   = 16;
    localparam int LIMB_COUNT  = 16;
    localparam int LIMB_W      = 4;
    localparam int LANES       = 4;
    localparam int ROW_LEN     = 16;
    localparam int COL_W       = 4;
    localparam int ROW_COUNT   = 16;
    localparam int ROW_W       = 4;
    localparam int TABLE_SIZE  = ROW_LEN * ROW_COUNT;
    localparam int CODE_W      = ROW_W + COL_W;
    localparam int DELTA_W     = COMP_BITS + 1;
    localparam int PROD_W      = 2 * COMP_BITS;
    localparam int DOT_W       = PROD_W + 2;

    // slave tdata layout, lowest bit first
    localparam int OFF_LIMB    = 0;
    localparam int OFF_COMP    = OFF_LIMB + LIMB_W;
    localparam int OFF_INDEX   = OFF_COMP + LANES * COMP_BITS;
    localparam int OFF_VALUE   = OFF_INDEX + CODE_W;
    localparam int IN_USED_W   = OFF_VALUE + COMP_BITS;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = LANES * CODE_W;
    localparam int CMD_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_ENCODE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SIGN,
        ST_START,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef logic signed [COMP_BITS-1:0] t_comp;

    typedef struct packed {
        logic load;
        logic mul;
        logic start;
    } t_lane_ctl;

    typedef struct packed {
        logic              done;
        logic [CODE_W-1:0] code;
        t_comp             new_ref;
    } t_lane_stat;

    localparam t_comp COMP_MAX = {1'b0, {(COMP_BITS-1){1'b1}}};
    localparam t_comp COMP_MIN = {1'b1, {(COMP_BITS-1){1'b0}}};

    // saturating negate: the most negative value maps to the most positive
    function automatic t_comp neg_sat(input t_comp a);
        t_comp r;
        if (a == COMP_MIN) begin
            r = COMP_MAX;
        end else begin
            r = -a;
        end
        return r;
    endfunction

    // saturating add of two components
    function automatic t_comp sat_add(input t_comp a, input t_comp b);
        logic [DELTA_W-1:0] s;
        t_comp              r;
        s = {a[COMP_BITS-1], a} + {b[COMP_BITS-1], b};
        if (s[DELTA_W-1] != s[DELTA_W-2]) begin
            r = s[DELTA_W-1] ? COMP_MIN : COMP_MAX;
        end else begin
            r = s[COMP_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/quaternion_delta_table_quantizer_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_delta_table_quantizer_top
// closed-loop table delta quantizer for limb-rotation quaternions
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (lsb first)                          tuser
//  s_axis    in   limb, comp_x, comp_y, comp_z, comp_w,      command
//                 entry_index, entry_value, zero pad
//  m_axis    out  code_x, code_y, code_z, code_w             flipped
//
//  load and set transactions are taken without leaving the idle state
//  encode passes through the multiply, sign, start and scan states until the
//  result register loads; the slowest lane scans n (1..16) 16-entry table rows;
//  each lane holds its own table copy and reads one row per cycle
//  reset clears control state only; table and limb references are undefined
//  until written, so there is no clearing pass
//  a result waiting on m_axis does not block the next transaction; only the
//  following encode result waits for the output register to free up
//
`timescale 1ns / 1ps

module quaternion_delta_table_quantizer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // limb, comp_x, comp_y, comp_z, comp_w, entry_index, entry_value, pad
    input  logic [qdtq_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // command
    input  logic [qdtq_pkg::CMD_W-1:0]          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // code_x, code_y, code_z, code_w
    output logic [qdtq_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // flipped
    output logic                                o_m_axis_tuser
);
    import qdtq_pkg::*;

    // reconstructed reference per limb, one component per lane
    logic [LANES-1:0][COMP_BITS-1:0] r_ref_mem [LIMB_COUNT];

    t_state                           r_state;
    t_state                           n_state;
    logic [LIMB_W-1:0]                r_limb;

    t_cmd                             in_cmd;
    logic [LIMB_W-1:0]                in_limb;
    logic [CODE_W-1:0]                in_index;
    t_comp                            in_value;
    logic                             s_accept;

    t_lane_ctl                        lane_ctl;
    logic                             flip_en;
    logic                             out_load;
    logic                             flip;
    logic                             out_free;
    logic                             all_done;

    logic [LANES-1:0][PROD_W-1:0]     lane_prod;
    t_lane_stat [LANES-1:0]           lane_stat;
    logic [LANES-1:0][COMP_BITS-1:0]  cur_ref;

    // field unpacking
    assign in_cmd   = t_cmd'(i_s_axis_tuser);
    assign in_limb  = i_s_axis_tdata[OFF_LIMB +: LIMB_W];
    assign in_index = i_s_axis_tdata[OFF_INDEX +: CODE_W];
    assign in_value = i_s_axis_tdata[OFF_VALUE +: COMP_BITS];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign cur_ref         = r_ref_mem[in_limb];

    always_comb begin
        all_done = 1'b1;
        for (int k = 0; k < LANES; k++) begin
            all_done = all_done && lane_stat[k].done;
        end
    end

    // sequencer: products, flip sign, lane scans, write-back
    always_comb begin
        n_state        = r_state;
        lane_ctl.load  = 1'b0;
        lane_ctl.mul   = 1'b0;
        lane_ctl.start = 1'b0;
        flip_en        = 1'b0;
        out_load       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_accept && (in_cmd == CMD_ENCODE)) begin
                    lane_ctl.load = 1'b1;
                    n_state       = ST_MUL;
                end
            end
            ST_MUL: begin
                lane_ctl.mul = 1'b1;
                n_state      = ST_SIGN;
            end
            ST_SIGN: begin
                flip_en = 1'b1;
                n_state = ST_START;
            end
            ST_START: begin
                lane_ctl.start = 1'b1;
                n_state        = ST_SCAN;
            end
            ST_SCAN: begin
                if (all_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // limb reference store: set on a set transaction, updated after encode
    always_ff @(posedge i_clk) begin
        if (s_accept && (in_cmd == CMD_ENCODE)) begin
            r_limb <= in_limb;
        end
        if (s_accept && (in_cmd == CMD_SET)) begin
            r_ref_mem[in_limb] <= i_s_axis_tdata[OFF_COMP +: LANES * COMP_BITS];
        end else if (out_load) begin
            for (int k = 0; k < LANES; k++) begin
                r_ref_mem[r_limb][k] <= lane_stat[k].new_ref;
            end
        end
    end

    // one lane per quaternion component
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        qdtq_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (lane_ctl),
            .i_flip     (flip),
            .i_comp     (i_s_axis_tdata[OFF_COMP + g * COMP_BITS +: COMP_BITS]),
            .i_ref      (cur_ref[g]),
            .i_wr_en    (s_accept && (in_cmd == CMD_LOAD)),
            .i_wr_index (in_index),
            .i_wr_value (in_value),
            .o_prod     (lane_prod[g]),
            .o_stat     (lane_stat[g])
        );
    end

    // dot product sign and the output register
    qdtq_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_prod     (lane_prod),
        .i_stat     (lane_stat),
        .i_flip_en  (flip_en),
        .i_out_load (out_load),
        .i_m_tready (i_m_axis_tready),
        .o_flip     (flip),
        .o_out_free (out_free),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== hw/rtl/qdtq_lane.sv =====
// ----------------------------------------------------------------------------
// qdtq_lane
// one component lane: reference product, delta, and a row-wide scan of its
// own copy of the delta table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdtq_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  qdtq_pkg::t_lane_ctl                 i_ctl,
    input  logic                                i_flip,
    input  qdtq_pkg::t_comp                     i_comp,
    input  qdtq_pkg::t_comp                     i_ref,
    input  logic                                i_wr_en,
    input  logic [qdtq_pkg::CODE_W-1:0]         i_wr_index,
    input  qdtq_pkg::t_comp                     i_wr_value,
    output logic signed [qdtq_pkg::PROD_W-1:0]  o_prod,
    output qdtq_pkg::t_lane_stat                o_stat
);
    import qdtq_pkg::*;

    // table copy, one row of entries per word
    logic [ROW_LEN-1:0][COMP_BITS-1:0] r_table [ROW_COUNT];
    logic [ROW_LEN-1:0][COMP_BITS-1:0] r_row;

    t_comp                      r_p;
    t_comp                      r_ref;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [DELTA_W-1:0]  r_delta;
    logic [ROW_W-1:0]           r_addr;
    logic [ROW_W-1:0]           r_drow;
    logic                       r_busy;
    logic                       r_rvalid;
    logic                       r_done;
    t_comp                      r_prev_last;
    logic [CODE_W-1:0]          r_code;
    t_comp                      r_sel_val;

    t_comp                      n_coded;
    logic [ROW_LEN-1:0]         n_hit;
    logic                       n_found;
    logic [COL_W-1:0]           n_col;
    logic                       n_last;
    logic [CODE_W-1:0]          n_code;
    t_comp                      n_val;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_table[i_wr_index[CODE_W-1 -: ROW_W]][i_wr_index[COL_W-1:0]] <= i_wr_value;
        end
        r_row <= r_table[r_addr];
    end

    assign n_coded = i_flip ? neg_sat(r_p) : r_p;

    // first entry above the delta; entry 0 of row 0 is never compared
    always_comb begin
        n_found = 1'b0;
        n_col   = '0;
        for (int j = 0; j < ROW_LEN; j++) begin
            n_hit[j] = ($signed({r_row[j][COMP_BITS-1], r_row[j]}) > r_delta)
                       && !((r_drow == '0) && (j == 0));
        end
        for (int j = ROW_LEN - 1; j >= 0; j--) begin
            if (n_hit[j]) begin
                n_found = 1'b1;
                n_col   = COL_W'(j);
            end
        end
        n_last = (r_drow == ROW_W'(ROW_COUNT - 1));
        if (n_found) begin
            n_code = {r_drow, n_col} - CODE_W'(1);
            n_val  = (n_col == '0) ? r_prev_last : r_row[n_col - COL_W'(1)];
        end else begin
            n_code = '1;
            n_val  = r_row[ROW_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rvalid <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_p   <= i_comp;
                r_ref <= i_ref;
            end
            if (i_ctl.mul) begin
                r_prod <= r_p * r_ref;
            end
            if (i_ctl.start) begin
                r_delta  <= {n_coded[COMP_BITS-1], n_coded} - {r_ref[COMP_BITS-1], r_ref};
                r_addr   <= '0;
                r_busy   <= 1'b1;
                r_rvalid <= 1'b0;
                r_done   <= 1'b0;
            end else if (r_busy) begin
                r_addr <= r_addr + ROW_W'(1);
                r_drow <= r_addr;
                if (r_rvalid && (n_found || n_last)) begin
                    r_busy    <= 1'b0;
                    r_rvalid  <= 1'b0;
                    r_done    <= 1'b1;
                    r_code    <= n_code;
                    r_sel_val <= n_val;
                end else begin
                    r_rvalid <= 1'b1;
                end
                if (r_rvalid) begin
                    r_prev_last <= r_row[ROW_LEN-1];
                end
            end
        end
    end

    assign o_prod         = r_prod;
    assign o_stat.done    = r_done;
    assign o_stat.code    = r_code;
    assign o_stat.new_ref = sat_add(r_ref, r_sel_val);

endmodule

// ===== hw/rtl/qdtq_merge.sv =====
// ----------------------------------------------------------------------------
// qdtq_merge
// combines the lanes: dot product sign for the flip, and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdtq_merge (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic [qdtq_pkg::LANES-1:0][qdtq_pkg::PROD_W-1:0]     i_prod,
    input  qdtq_pkg::t_lane_stat [qdtq_pkg::LANES-1:0]           i_stat,
    input  logic                                                 i_flip_en,
    input  logic                                                 i_out_load,
    input  logic                                                 i_m_tready,
    output logic                                                 o_flip,
    output logic                                                 o_out_free,
    output logic                                                 o_m_tvalid,
    output logic [qdtq_pkg::OUT_TDATA_W-1:0]                     o_m_tdata,
    output logic                                                 o_m_tuser
);
    import qdtq_pkg::*;

    logic signed [DOT_W-1:0]  n_dot;
    logic                     r_flip;
    logic                     r_valid;
    logic [OUT_TDATA_W-1:0]   r_data;
    logic                     r_user;

    always_comb begin
        n_dot = '0;
        for (int k = 0; k < LANES; k++) begin
            n_dot = n_dot + DOT_W'($signed(i_prod[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_flip_en) begin
                r_flip <= n_dot[DOT_W-1];
            end
            if (i_out_load) begin
                r_valid <= 1'b1;
                r_user  <= r_flip;
                for (int k = 0; k < LANES; k++) begin
                    r_data[k*CODE_W +: CODE_W] <= i_stat[k].code;
                end
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_flip     = r_flip;
    assign o_out_free = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_user;

endmodule

// ===== hw/rtl/qdtq_checker.sv =====
// ----------------------------------------------------------------------------
// qdtq_port_checks
// port-level checks of the quaternion delta table quantizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qdtq_port_checks (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    input  logic                                o_s_axis_tready,
    input  logic [qdtq_pkg::CMD_W-1:0]          i_s_axis_tuser,
    input  logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [qdtq_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                                o_m_axis_tuser
);
    import qdtq_pkg::*;

    logic                   enc_acc;
    logic                   out_acc;
    logic                   m_stall;
    logic [OUT_TDATA_W:0]   m_word;
    logic [1:0]             r_pend;

    assign enc_acc = i_s_axis_tvalid && o_s_axis_tready
                     && (i_s_axis_tuser == CMD_ENCODE);
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign m_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign m_word  = {o_m_axis_tuser, o_m_axis_tdata};

    // encodes taken whose result has not yet been delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (enc_acc && !out_acc) begin
            r_pend <= r_pend + 2'd1;
        end else if (out_acc && !enc_acc) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    `ASSERT_CLK_ANY(a_reset_clears_valid, !i_rst_n |=> !o_m_axis_tvalid, "valid after reset")
    `ASSERT_CLK(a_hold, m_stall |=> o_m_axis_tvalid && $stable(m_word), "stalled result changed")
    `ASSERT_CLK(a_encode_busy, enc_acc |=> !o_s_axis_tready, "ready right after encode")
    `ASSERT_CLK(a_result_has_source, o_m_axis_tvalid |-> r_pend != 2'd0, "result without encode")
    `ASSERT_CLK(a_pend_bounded, r_pend != 2'd3, "too many encodes in flight")

endmodule

bind quaternion_delta_table_quantizer_top qdtq_port_checks u_qdtq_port_checks (.*);
